[design/assert_macros.svh]
// Assertion macros for the row blur RTL (included by ecbb_back).
// Define NO_ASSERTIONS to compile them out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(name, clk, rst_n, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(name, clk, rst_n, expr, msg)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

[design/ecbb_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the edge clipped row blur.
// Used by every module of the block; depends on nothing.
package ecbb_pkg;

    localparam int DEF_MAX_RADIUS  = 63;
    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int DEF_MAX_HEIGHT  = 1024;
    localparam int DEF_SAMPLE_BITS = 16;

    // widths fixed by the register map and the result format
    localparam int RAD_W     = 6;
    localparam int COL_W     = 11;
    localparam int COL_OUT_W = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 11;
    localparam int REG_LIMIT = 2047;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED    = 2'd3;

    // effective settings seen by the back end
    typedef struct packed {
        logic             restart;
        logic [RAD_W-1:0] r;
        logic [COL_W-1:0] w_last;
    } cfg_t;

    // classification of one accepted pixel
    typedef struct packed {
        logic emit_one;
        logic row_last;
        logic frame_last;
    } cmd_flags_t;

endpackage

[design/ecbb_front.sv]
`timescale 1ns / 1ps
// Front end: config registers, clamping, column/row tracking and
// classification of each accepted pixel. Uses ecbb_pkg.
module ecbb_front #(
    parameter int MAX_RADIUS  = 63,
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ecbb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ecbb_pkg::CFG_DAT_W-1:0]   cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [SAMPLE_BITS-1:0]           s_sample,
    output logic                             push_valid,
    input  logic                             push_ready,
    output logic [SAMPLE_BITS-1:0]           push_sample,
    output logic [ecbb_pkg::COL_W-1:0]       push_col,
    output ecbb_pkg::cmd_flags_t             push_flags,
    output ecbb_pkg::cfg_t                   cfg
);
    import ecbb_pkg::*;

    localparam int WCAP = (MAX_WIDTH > REG_LIMIT) ? REG_LIMIT : MAX_WIDTH;
    localparam int HCAP = (MAX_HEIGHT > REG_LIMIT) ? REG_LIMIT : MAX_HEIGHT;
    localparam int RCAP = (MAX_RADIUS > 63) ? 63 : MAX_RADIUS;
    localparam logic [COL_W-1:0] WCAP_C = COL_W'(WCAP);
    localparam logic [COL_W-1:0] HCAP_C = COL_W'(HCAP);
    localparam logic [RAD_W-1:0] RCAP_C = RAD_W'(RCAP);

    logic [RAD_W-1:0] radius_reg, radius_next;
    logic [COL_W-1:0] width_reg, width_next;
    logic [COL_W-1:0] count_reg, count_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [COL_W-1:0] row_reg, row_next;

    logic [COL_W-1:0] w_eff, h_eff, w_last, h_last;
    logic [RAD_W-1:0] r_cap, r_eff;
    logic             restart, accept;

    always_comb begin
        w_eff = (width_reg == '0) ? COL_W'(1) : ((width_reg > WCAP_C) ? WCAP_C : width_reg);
        h_eff = (count_reg == '0) ? COL_W'(1) : ((count_reg > HCAP_C) ? HCAP_C : count_reg);
        w_last = w_eff - COL_W'(1);
        h_last = h_eff - COL_W'(1);
        r_cap = (radius_reg > RCAP_C) ? RCAP_C : radius_reg;
        r_eff = ({{(COL_W-RAD_W){1'b0}}, r_cap} > w_last) ? w_last[RAD_W-1:0] : r_cap;
    end

    assign cfg_ready = 1'b1;
    assign restart   = cfg_valid && (cfg_index != REG_UNUSED);
    assign s_tready  = push_ready;
    assign accept    = s_tvalid && push_ready;

    assign push_valid          = s_tvalid;
    assign push_sample         = s_sample;
    assign push_col            = col_reg;
    assign push_flags.emit_one   = (col_reg >= {{(COL_W-RAD_W){1'b0}}, r_eff});
    assign push_flags.row_last   = (col_reg == w_last);
    assign push_flags.frame_last = (row_reg == h_last);

    assign cfg.restart = restart;
    assign cfg.r       = r_eff;
    assign cfg.w_last  = w_last;

    always_comb begin
        radius_next = radius_reg;
        width_next  = width_reg;
        count_next  = count_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_RADIUS:    radius_next = cfg_data[RAD_W-1:0];
                REG_ROW_WIDTH: width_next  = cfg_data;
                REG_ROW_COUNT: count_next  = cfg_data;
                default: ;
            endcase
        end
        if (restart) begin
            col_next = '0;
            row_next = '0;
        end else if (accept) begin
            if (col_reg == w_last) begin
                col_next = '0;
                row_next = (row_reg == h_last) ? '0 : row_reg + COL_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RAD_W'(1);
            width_reg  <= COL_W'(1024);
            count_reg  <= COL_W'(1024);
            col_reg    <= '0;
            row_reg    <= '0;
        end else begin
            radius_reg <= radius_next;
            width_reg  <= width_next;
            count_reg  <= count_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

endmodule

[design/ecbb_queue.sv]
`timescale 1ns / 1ps
// Small FIFO that decouples the front end from the back end.
// Depth must be a power of two; pointers wrap naturally. Uses ecbb_pkg.
module ecbb_queue #(
    parameter int DATA_W = 30
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);
    import ecbb_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[design/ecbb_back.sv]
`timescale 1ns / 1ps
// Back end: window memory, running sum, bit-serial divider and output
// register. Uses ecbb_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ecbb_back #(
    parameter int MAX_RADIUS  = 63,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  ecbb_pkg::cfg_t                   cfg,
    input  logic                             q_valid,
    output logic                             q_ready,
    input  logic [SAMPLE_BITS-1:0]           q_sample,
    input  logic [ecbb_pkg::COL_W-1:0]       q_col,
    input  ecbb_pkg::cmd_flags_t             q_flags,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [SAMPLE_BITS-1:0]           m_average,
    output logic [ecbb_pkg::COL_OUT_W-1:0]   m_column,
    output logic                             m_row_end,
    output logic                             m_frame_end,
    output logic                             m_last
);
    import ecbb_pkg::*;

    localparam int AW     = $clog2(2 * MAX_RADIUS + 2);
    localparam int DEPTH  = 1 << AW;
    localparam int SUM_W  = SAMPLE_BITS + AW;
    localparam int STEP_W = $clog2(SAMPLE_BITS);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOAD = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [SAMPLE_BITS-1:0] win_mem [DEPTH];
    logic [SAMPLE_BITS-1:0] rd_data_reg;

    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [COL_W-1:0]       o_reg, o_next;
    logic [COL_W-1:0]       c_reg, c_next;
    logic                   row_last_reg, row_last_next;
    logic                   frame_last_reg, frame_last_next;
    logic [AW-1:0]          rem_reg, rem_next;
    logic [SAMPLE_BITS-1:0] quo_reg, quo_next;
    logic [AW-1:0]          span_reg, span_next;
    logic [STEP_W-1:0]      step_reg, step_next;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [SAMPLE_BITS-1:0] avg_reg, avg_next;
    logic [COL_OUT_W-1:0]   col_out_reg, col_out_next;
    logic                   row_end_reg, row_end_next;
    logic                   frame_end_reg, frame_end_next;
    logic                   last_reg, last_next;

    logic [COL_W-1:0] r_ext, lo_col, span_full;
    logic             o_ge_r, pop, out_free, out_fire, more;
    logic [AW-1:0]    rd_addr;
    logic [AW:0]      trial, diff;
    logic             ge;

    assign r_ext     = {{(COL_W-RAD_W){1'b0}}, cfg.r};
    assign o_ge_r    = (o_reg >= r_ext);
    assign lo_col    = o_reg - r_ext;
    assign rd_addr   = lo_col[AW-1:0];
    assign span_full = c_reg - (o_ge_r ? lo_col : '0) + COL_W'(1);

    assign trial = {rem_reg, quo_reg[SAMPLE_BITS-1]};
    assign diff  = trial - {1'b0, span_reg};
    assign ge    = (trial >= {1'b0, span_reg});

    assign q_ready  = (state_reg == ST_IDLE);
    assign pop      = q_valid && q_ready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_fire = (state_reg == ST_OUT) && out_free;
    // at a row end keep going until the last column is out
    assign more     = row_last_reg && (o_reg != cfg.w_last);

    always_ff @(posedge aclk) begin
        if (pop) begin
            win_mem[q_col[AW-1:0]] <= q_sample;
        end
        rd_data_reg <= win_mem[rd_addr];
    end

    always_comb begin
        state_next      = state_reg;
        sum_next        = sum_reg;
        o_next          = o_reg;
        c_next          = c_reg;
        row_last_next   = row_last_reg;
        frame_last_next = frame_last_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        span_next       = span_reg;
        step_next       = step_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        avg_next        = avg_reg;
        col_out_next    = col_out_reg;
        row_end_next    = row_end_reg;
        frame_end_next  = frame_end_reg;
        last_next       = last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (pop) begin
                    sum_next        = sum_reg + SUM_W'(q_sample);
                    c_next          = q_col;
                    row_last_next   = q_flags.row_last;
                    frame_last_next = q_flags.frame_last;
                    state_next      = q_flags.emit_one ? ST_LOAD : ST_IDLE;
                end
            end
            ST_LOAD: begin
                span_next  = span_full[AW-1:0];
                rem_next   = sum_reg[SUM_W-1:SAMPLE_BITS];
                quo_next   = sum_reg[SAMPLE_BITS-1:0];
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                rem_next  = ge ? diff[AW-1:0] : trial[AW-1:0];
                quo_next  = {quo_reg[SAMPLE_BITS-2:0], ge};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SAMPLE_BITS - 1)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_tvalid_next  = 1'b1;
                    avg_next       = quo_reg;
                    col_out_next   = o_reg[COL_OUT_W-1:0];
                    row_end_next   = (o_reg == cfg.w_last);
                    frame_end_next = (o_reg == cfg.w_last) && frame_last_reg;
                    last_next      = !more;
                    if (o_ge_r) begin
                        sum_next = sum_reg - SUM_W'(rd_data_reg);
                    end
                    o_next = o_reg + COL_W'(1);
                    if (more) begin
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_IDLE;
                        if (row_last_reg) begin
                            sum_next = '0;
                            o_next   = '0;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (cfg.restart) begin
            sum_next = '0;
            o_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            sum_reg      <= '0;
            o_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sum_reg      <= sum_next;
            o_reg        <= o_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        c_reg          <= c_next;
        row_last_reg   <= row_last_next;
        frame_last_reg <= frame_last_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        span_reg       <= span_next;
        step_reg       <= step_next;
        avg_reg        <= avg_next;
        col_out_reg    <= col_out_next;
        row_end_reg    <= row_end_next;
        frame_end_reg  <= frame_end_next;
        last_reg       <= last_next;
    end

    assign m_tvalid    = m_tvalid_reg;
    assign m_average   = avg_reg;
    assign m_column    = col_out_reg;
    assign m_row_end   = row_end_reg;
    assign m_frame_end = frame_end_reg;
    assign m_last      = last_reg;

    `ASSERT_ALWAYS(a_rem_below_span, aclk, aresetn, (state_reg != ST_DIV) || (rem_reg < span_reg), "divider remainder not below span")
    `ASSERT_ALWAYS(a_out_col_in_row, aclk, aresetn, o_reg <= cfg.w_last, "output column past row end")
    `ASSERT_NEXT(a_row_flush_clears, aclk, aresetn, out_fire && row_last_reg && !more, (sum_reg == '0) && (o_reg == '0), "row end did not clear sum")
    `ASSERT_NEXT(a_last_back_idle, aclk, aresetn, out_fire && !more, state_reg == ST_IDLE, "back end busy after final result")

endmodule

[design/edge_clipped_box_blur_row.sv]
`timescale 1ns / 1ps
// Row box blur with the window clipped at row ends. Each result costs one
// read, one quotient bit per cycle in the shared divider and one output
// step held by m_tready; the back end takes no new pixel until it is idle.
// A pixel without a result only adds to the running sum; a row end emits
// radius + 1 results back to back through the same divider.
// aresetn (synchronous, active low) restores radius 1 and 1024 x 1024, column 0.
module edge_clipped_box_blur_row #(
    parameter int MAX_RADIUS  = ecbb_pkg::DEF_MAX_RADIUS,
    parameter int MAX_WIDTH   = ecbb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = ecbb_pkg::DEF_MAX_HEIGHT,
    parameter int SAMPLE_BITS = ecbb_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        cfg_valid,
    output logic                                        cfg_ready,
    input  logic [ecbb_pkg::CFG_IDX_W-1:0]              cfg_index,
    input  logic [ecbb_pkg::CFG_DAT_W-1:0]              cfg_data,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // s_tdata: sample
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]            s_tdata,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // m_tdata: average, column
    output logic [((SAMPLE_BITS+ecbb_pkg::COL_OUT_W+7)/8)*8-1:0] m_tdata,
    // m_tuser: row_end, frame_end
    output logic [1:0]                                  m_tuser,
    output logic                                        m_tlast
);
    import ecbb_pkg::*;

    localparam int M_TDATA_W = ((SAMPLE_BITS + COL_OUT_W + 7) / 8) * 8;
    localparam int CMD_W     = $bits(cmd_flags_t) + COL_W + SAMPLE_BITS;

    cfg_t                   cfg;
    logic                   push_valid, push_ready, pop_valid, pop_ready;
    logic [SAMPLE_BITS-1:0] push_sample, pop_sample;
    logic [COL_W-1:0]       push_col, pop_col;
    cmd_flags_t             push_flags, pop_flags;
    logic [CMD_W-1:0]       push_data, pop_data;

    logic [SAMPLE_BITS-1:0] average;
    logic [COL_OUT_W-1:0]   column;
    logic                   row_end, frame_end;

    ecbb_front #(
        .MAX_RADIUS (MAX_RADIUS),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_sample   (s_tdata[SAMPLE_BITS-1:0]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_sample(push_sample),
        .push_col   (push_col),
        .push_flags (push_flags),
        .cfg        (cfg)
    );

    assign push_data = {push_flags, push_col, push_sample};

    ecbb_queue #(
        .DATA_W(CMD_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_data (push_data),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data)
    );

    assign {pop_flags, pop_col, pop_sample} = pop_data;

    ecbb_back #(
        .MAX_RADIUS (MAX_RADIUS),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .q_valid    (pop_valid),
        .q_ready    (pop_ready),
        .q_sample   (pop_sample),
        .q_col      (pop_col),
        .q_flags    (pop_flags),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_average  (average),
        .m_column   (column),
        .m_row_end  (row_end),
        .m_frame_end(frame_end),
        .m_last     (m_tlast)
    );

    assign m_tdata = M_TDATA_W'({column, average});
    assign m_tuser = {frame_end, row_end};

endmodule
